### sv/qfb_pkg.sv
// ----------------------------------------------------------------------------
// qfb_pkg
// shared types, constants and byte/check helpers of the query frame builder
// ----------------------------------------------------------------------------
package qfb_pkg;

  localparam int unsigned FrameLen  = 21;
  localparam int unsigned BodyLen   = 19;
  localparam int unsigned IdxW      = $clog2(FrameLen);
  localparam logic [15:0] CheckPoly = 16'h1005;

  // frame byte offsets
  localparam logic [IdxW-1:0] OffLenHi  = IdxW'(0);
  localparam logic [IdxW-1:0] OffLenLo  = IdxW'(1);
  localparam logic [IdxW-1:0] OffVer0   = IdxW'(2);
  localparam logic [IdxW-1:0] OffVer1   = IdxW'(3);
  localparam logic [IdxW-1:0] OffHost   = IdxW'(4);
  localparam logic [IdxW-1:0] OffPad0   = IdxW'(5);
  localparam logic [IdxW-1:0] OffPad1   = IdxW'(6);
  localparam logic [IdxW-1:0] OffPad2   = IdxW'(7);
  localparam logic [IdxW-1:0] OffPad3   = IdxW'(8);
  localparam logic [IdxW-1:0] OffRoad   = IdxW'(9);
  localparam logic [IdxW-1:0] OffFrmId  = IdxW'(10);
  localparam logic [IdxW-1:0] OffType   = IdxW'(11);
  localparam logic [IdxW-1:0] OffOp0    = IdxW'(12);
  localparam logic [IdxW-1:0] OffOp1    = IdxW'(13);
  localparam logic [IdxW-1:0] OffOp2    = IdxW'(14);
  localparam logic [IdxW-1:0] OffClass  = IdxW'(15);
  localparam logic [IdxW-1:0] OffObject = IdxW'(16);
  localparam logic [IdxW-1:0] OffAttr   = IdxW'(17);
  localparam logic [IdxW-1:0] OffElem   = IdxW'(18);
  localparam logic [IdxW-1:0] OffChkHi  = IdxW'(19);
  localparam logic [IdxW-1:0] OffChkLo  = IdxW'(20);

  // fixed header byte values
  localparam logic [7:0] ByteZero   = 8'h00;
  localparam logic [7:0] ByteOne    = 8'h01;
  localparam logic [7:0] ByteFour   = 8'h04;
  localparam logic [7:0] ByteBodyLn = 8'(BodyLen);

  // configuration register indexes
  localparam logic [1:0] RegHostId    = 2'd0;
  localparam logic [1:0] RegRoadId    = 2'd1;
  localparam logic [1:0] RegQueryType = 2'd2;

  // one query with the configuration attached at acceptance
  typedef struct packed {
    logic [7:0] query_type;
    logic [7:0] road_id;
    logic [7:0] host_id;
    logic [7:0] element_num;
    logic [7:0] attribute_num;
    logic [7:0] object_num;
    logic [7:0] data_class;
  } query_t;

  // push handshake from the front into the queue
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  // select the frame byte at offset idx
  function automatic logic [7:0] frame_byte_sel(logic [IdxW-1:0] idx, query_t q,
                                                logic [15:0] chk);
    logic [7:0] b;
    b = ByteZero;
    unique case (idx)
      OffLenHi:  b = ByteZero;
      OffLenLo:  b = ByteBodyLn;
      OffVer0:   b = ByteOne;
      OffVer1:   b = ByteOne;
      OffHost:   b = q.host_id;
      OffPad0:   b = ByteZero;
      OffPad1:   b = ByteZero;
      OffPad2:   b = ByteZero;
      OffPad3:   b = ByteZero;
      OffRoad:   b = q.road_id;
      OffFrmId:  b = ByteOne;
      OffType:   b = q.query_type;
      OffOp0:    b = ByteOne;
      OffOp1:    b = ByteOne;
      OffOp2:    b = ByteFour;
      OffClass:  b = q.data_class;
      OffObject: b = q.object_num;
      OffAttr:   b = q.attribute_num;
      OffElem:   b = q.element_num;
      OffChkHi:  b = chk[15:8];
      OffChkLo:  b = chk[7:0];
      default:   b = ByteZero;
    endcase
    return b;
  endfunction

  // check update over one byte, msb first
  function automatic logic [15:0] check_byte(logic [15:0] acc_in, logic [7:0] data);
    logic [15:0] acc;
    logic        top;
    acc = acc_in;
    for (int i = 7; i >= 0; i--) begin
      top = acc[15];
      acc = {acc[14:0], 1'b0};
      if (top) begin
        acc = acc ^ CheckPoly;
      end
      if (data[i]) begin
        acc = acc ^ CheckPoly;
      end
    end
    return acc;
  endfunction

endpackage

### sv/qfb_front.sv
// ----------------------------------------------------------------------------
// qfb_front
// accepts queries, holds the configuration and tags each query with it
// ----------------------------------------------------------------------------
module qfb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [31:0]     in_data_i,
  output qfb_pkg::hs_t    push_o,
  input  logic            push_ready_i,
  output qfb_pkg::query_t entry_o
);

  logic [7:0]      host_id_q, road_id_q, query_type_q;
  logic            valid_q, valid_d;
  qfb_pkg::query_t entry_q;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_id_q    <= '0;
      road_id_q    <= '0;
      query_type_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qfb_pkg::RegHostId:    host_id_q    <= cfg_data_i;
        qfb_pkg::RegRoadId:    road_id_q    <= cfg_data_i;
        qfb_pkg::RegQueryType: query_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q.data_class    <= in_data_i[7:0];
      entry_q.object_num    <= in_data_i[15:8];
      entry_q.attribute_num <= in_data_i[23:16];
      entry_q.element_num   <= in_data_i[31:24];
      entry_q.host_id       <= host_id_q;
      entry_q.road_id       <= road_id_q;
      entry_q.query_type    <= query_type_q;
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.ready = push_ready_i;
  assign entry_o      = entry_q;

endmodule

### sv/qfb_fifo.sv
// ----------------------------------------------------------------------------
// qfb_fifo
// two-entry queue of tagged queries between front and back
// ----------------------------------------------------------------------------
module qfb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  qfb_pkg::query_t wdata_i,
  input  logic            pop_i,
  output logic            empty_o,
  output qfb_pkg::query_t rdata_o
);

  qfb_pkg::query_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q, count_d;
  logic            do_push;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pop only from a filled queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("qfb_fifo: pop while empty");
  // occupancy never goes past two entries
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("qfb_fifo: count overflow");

endmodule

### sv/qfb_back.sv
// ----------------------------------------------------------------------------
// qfb_back
// serializes one query into a 21-byte frame and runs the check on the fly
// ----------------------------------------------------------------------------
module qfb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  qfb_pkg::query_t q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic [qfb_pkg::IdxW-1:0] cnt_q;
  logic [15:0]              crc_q;
  logic                     out_valid_q;
  logic [7:0]               out_byte_q;
  logic                     out_last_q;
  logic                     load;
  logic                     at_last;
  logic [7:0]               cur_byte;

  assign load     = !q_empty_i && (!out_valid_q || out_ready_i);
  assign at_last  = (cnt_q == qfb_pkg::OffChkLo);
  assign cur_byte = qfb_pkg::frame_byte_sel(cnt_q, q_data_i, crc_q);
  assign pop_o    = load && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (at_last) begin
          cnt_q <= '0;
          crc_q <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q < qfb_pkg::OffChkHi) begin
            crc_q <= qfb_pkg::check_byte(crc_q, cur_byte);
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= cur_byte;
      out_last_q <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // byte counter stays inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cnt_q <= qfb_pkg::OffChkLo)
    else $error("qfb_back: byte counter out of range");
  // a frame end restarts the counter and the check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   pop_o |=> (cnt_q == '0) && (crc_q == '0))
    else $error("qfb_back: frame end did not restart");
  // loading the last byte pops the queue in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   load && at_last |-> pop_o && !q_empty_i)
    else $error("qfb_back: last byte without pop");

endmodule

### sv/query_frame_builder_crc16_unit.sv
// ----------------------------------------------------------------------------
// query_frame_builder_crc16_unit
// builds a 21-byte query frame with a 16-bit check, one byte per transfer
// ----------------------------------------------------------------------------
// path: a query passes the front register, the queue and the back output register
// per query: 21 frame bytes, paced by the one-byte output channel
// the front register and two-entry queue take new queries while a frame drains
// reset: async active low, clears configuration to zero and empties all stages
// frame: header, four query bytes, check high byte, check low byte (tlast)
// ----------------------------------------------------------------------------
module query_frame_builder_crc16_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,      // 0 host_id, 1 road_id, 2 query_type
  input  logic [7:0]  cfg_data_i,
  // query input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // data_class, object_num, attribute_num, element_num
  // frame byte output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // frame_byte
  output logic        m_axis_tlast    // last_byte
);

  qfb_pkg::hs_t    push;
  qfb_pkg::query_t front_entry;
  qfb_pkg::query_t q_data;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  // front: accepts the query and attaches the current configuration
  qfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .push_o       (push),
    .push_ready_i (!q_full),
    .entry_o      (front_entry)
  );

  // short queue decouples query intake from frame output
  qfb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push.valid),
    .full_o  (q_full),
    .wdata_i (front_entry),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  // back: byte serializer with the running check
  qfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // a front entry moves only when the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push.valid && push.ready |-> !q_full)
    else $error("top: push into full queue");
  // a stalled byte and its tlast stay put until the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid && !m_axis_tready |=>
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("top: output changed while stalled");
  // output valid never rises unless the queue held a query beforehand
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(m_axis_tvalid) |-> $past(!q_empty))
    else $error("top: output valid without queued query");

endmodule

### sim/query_frame_builder_crc16_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_frame_builder_crc16_unit_tb
// self-checking bench for the query frame builder with its 16-bit check
// ----------------------------------------------------------------------------
// queries go in through a driver fed from a pending queue; every accepted
// query is turned into its 21 expected frame bytes by a local frame and check
// builder, and a monitor compares each output transfer against the oldest one.
// the run moves through four handshake mixes and several register settings,
// reprogramming the registers only while the block is drained
// ----------------------------------------------------------------------------
module query_frame_builder_crc16_unit_tb;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PrintCap    = 40;    // keep the log short on a bad run
  localparam logic [1:0]  RegUnused   = 2'd3;  // no register behind this index

  // one query as it sits on s_axis_tdata, first field in the low byte
  typedef struct packed {
    logic [7:0] element_num;
    logic [7:0] attribute_num;
    logic [7:0] object_num;
    logic [7:0] data_class;
  } query_word_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // clock, reset and block inputs, all driven to known values from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = qfb_pkg::RegHostId;
  logic [7:0]  cfg_data_i    = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // data_class, object_num, attribute_num, element_num
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // frame_byte
  logic        m_axis_tlast;        // last_byte

  // local copy of the configuration registers
  logic [7:0] host_id_cfg    = 8'h00;
  logic [7:0] road_id_cfg    = 8'h00;
  logic [7:0] query_type_cfg = 8'h00;

  query_word_t queries_waiting[$];   // queries not yet handed to the block
  frame_byte_t frame_bytes_due[$];   // frame bytes the block still owes

  int unsigned queries_queued = 0;
  int unsigned queries_sent   = 0;
  int unsigned bytes_seen     = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // idling odds in percent, changed only between phases
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  query_frame_builder_crc16_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // frame builder: header, query bytes, then the check over the first 19 bytes
  // --------------------------------------------------------------------------
  function automatic void build_frame(input query_word_t q);
    logic [7:0]  body [0:18];
    logic [15:0] crc;
    logic        feedback;
    frame_byte_t fb;
    body = '{8'h00, 8'h13, 8'h01, 8'h01, host_id_cfg,
             8'h00, 8'h00, 8'h00, 8'h00, road_id_cfg,
             8'h01, query_type_cfg, 8'h01, 8'h01, 8'h04,
             q.data_class, q.object_num, q.attribute_num, q.element_num};
    crc = 16'h0000;
    for (int n = 0; n < 19; n++) begin
      for (int b = 7; b >= 0; b--) begin
        // the poly goes in once for the bit shifted out and once for a set
        // data bit, so the two cancel when both are set
        feedback = crc[15] ^ body[n][b];
        crc = {crc[14:0], 1'b0} ^ (feedback ? qfb_pkg::CheckPoly : 16'h0000);
      end
    end
    for (int n = 0; n < 19; n++) begin
      fb.data = body[n];
      fb.last = 1'b0;
      frame_bytes_due.push_back(fb);
    end
    fb.data = crc[15:8];
    fb.last = 1'b0;
    frame_bytes_due.push_back(fb);
    fb.data = crc[7:0];
    fb.last = 1'b1;
    frame_bytes_due.push_back(fb);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= PrintCap) begin
      $display("mismatch cycle %0d byte %0d: %s got %02h want %02h",
               cycle_count, bytes_seen, what, got, want);
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: holds a query until its transfer, then may idle at random in any free cycle
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        // registers are only touched while drained, so this is the setting
        // the block latched with the query
        build_frame(query_word_t'(s_axis_tdata));
        queries_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (queries_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= queries_waiting.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each frame byte transfer, stalls at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : frame_monitor
    frame_byte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_seen++;
        if (frame_bytes_due.size() == 0) begin
          report_mismatch("byte with no query behind it", m_axis_tdata, 8'h00);
        end else begin
          want = frame_bytes_due.pop_front();
          if (m_axis_tdata !== want.data) begin
            report_mismatch("frame_byte", m_axis_tdata, want.data);
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch("last_byte", {7'd0, m_axis_tlast}, {7'd0, want.last});
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still due",
               cycle_count, frame_bytes_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequencing helpers
  // --------------------------------------------------------------------------
  function automatic void queue_query(input logic [31:0] w);
    queries_waiting.push_back(query_word_t'(w));
    queries_queued++;
  endfunction

  // waits until every queued query is taken and every frame byte is back, then lets the block settle
  task automatic wait_drained();
    while (!(queries_sent == queries_queued && frame_bytes_due.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    reg_writes++;
    case (idx)
      qfb_pkg::RegHostId:    host_id_cfg    = val;
      qfb_pkg::RegRoadId:    road_id_cfg    = val;
      qfb_pkg::RegQueryType: query_type_cfg = val;
      default:               ;  // unmapped index, write dropped
    endcase
  endtask

  task automatic write_all_regs(input logic [7:0] host, input logic [7:0] road,
                                input logic [7:0] qtype);
    write_reg(qfb_pkg::RegHostId, host);
    write_reg(qfb_pkg::RegRoadId, road);
    write_reg(qfb_pkg::RegQueryType, qtype);
  endtask

  task automatic random_queries(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      queue_query($urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 1: no idling; reset configuration first, then all-ones registers
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_query(32'h0000_0000);
    queue_query(32'hFFFF_FFFF);
    queue_query(32'h0000_00FF);
    queue_query(32'h0000_FF00);
    queue_query(32'h00FF_0000);
    queue_query(32'hFF00_0000);
    wait_drained();
    write_all_regs(8'hFF, 8'hFF, 8'hFF);
    queue_query(32'h0000_0000);
    queue_query(32'hFFFF_FFFF);
    queue_query(32'hAAAA_AAAA);
    queue_query(32'h5555_5555);
    queue_query(32'h0102_0408);
    queue_query(32'h8040_2010);
    queue_query(32'h7F7F_7F7F);
    queue_query(32'h8080_8080);
    random_queries(40);
    wait_drained();

    // phase 2: sender mostly idle; mixed extremes, plus a write to no register
    send_idle_pct  = 84;
    recv_stall_pct = 0;
    write_all_regs(8'h00, 8'hFF, 8'h5A);
    write_reg(RegUnused, 8'hC3);
    random_queries(60);
    wait_drained();

    // phase 3: receiver mostly stalled; random settings
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    write_all_regs(8'($urandom()), 8'($urandom()), 8'($urandom()));
    random_queries(60);
    wait_drained();

    // phase 4: both sides idle now and then; the sender pauses mid-phase
    // until every owed byte is back
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    write_all_regs(8'h80, 8'h01, 8'($urandom()));
    random_queries(35);
    wait_drained();
    random_queries(35);
    wait_drained();

    if (frame_bytes_due.size() != 0) begin
      report_mismatch("bytes never delivered", 8'(frame_bytes_due.size()), 8'h00);
    end

    $display("ran %0d queries into %0d frame bytes over %0d cycles", queries_sent,
             bytes_seen, cycle_count);
    $display("four handshake mixes, %0d register writes, %0d mismatches", reg_writes,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
sv/qfb_pkg.sv
sv/qfb_front.sv
sv/qfb_fifo.sv
sv/qfb_back.sv
sv/query_frame_builder_crc16_unit.sv
sim/query_frame_builder_crc16_unit_tb.sv
